### design/word_wrap_line_folder_macros.svh
// Assertion macros shared by the word wrap line folder.
`ifndef WORD_WRAP_LINE_FOLDER_MACROS_SVH
`define WORD_WRAP_LINE_FOLDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WWLF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("word wrap line folder: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define WWLF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("word wrap line folder: next-cycle check failed");

`endif

### design/wwlf_pkg.sv
// Shared constants, types and command/status structs of the word wrap line folder.
package wwlf_pkg;

    localparam int LINE_MAX_DEF = 128;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BREAK_PUNCT = 8'd1;

    localparam logic [7:0] LINE_WIDTH_RST  = 8'd80;
    localparam logic       BREAK_PUNCT_RST = 1'b0;

    localparam logic [7:0] SPACE_BYTE   = 8'h20;
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    typedef struct packed {
        logic append;
        logic start;
        logic emit;
        logic move;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic needs_fold;
        logic emit_done;
        logic move_done;
    } t_status;

endpackage

### design/wwlf_ctrl.sv
// Controller state machine that sequences append, emit, compaction and finish steps.
module wwlf_ctrl
    import wwlf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EMIT   = 4'b0010,
        S_MOVE   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        o_cmd        = '0;
        o_cmd.append = accept && !i_status.needs_fold;
        o_cmd.start  = accept && i_status.needs_fold;
        o_cmd.emit   = (r_state == S_EMIT);
        o_cmd.move   = (r_state == S_MOVE);
        o_cmd.finish = (r_state == S_FINISH);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_status.needs_fold) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.emit_done) begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                if (i_status.move_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### design/wwlf_dp.sv
// Datapath with the line memory, break tracking, byte packer and output register.
module wwlf_dp
    import wwlf_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic [7:0]            i_char_in,
    input  logic                  i_end_of_text,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_ready,
    output logic                  o_valid,
    output logic [63:0]           o_out_bytes,
    output logic [3:0]            o_out_count,
    output logic                  o_last
);

    localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam int CW = $clog2(LINE_MAX + 1);
    localparam int LW = $clog2(LINE_MAX + 2);

    function automatic logic is_punct(input logic [7:0] c);
        return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

    logic [7:0]    r_mem [LINE_MAX];
    logic [7:0]    r_mem_q;

    logic [7:0]    r_line_width;
    logic          r_bop;
    logic [CW-1:0] r_fill;
    logic [AW-1:0] r_bp;
    logic          r_bv;
    logic          r_bpunct;

    logic [7:0]    r_c;
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_mem_len;
    logic [CW-1:0] r_tail;
    logic [CW-1:0] r_src;
    logic          r_wr_c;
    logic [AW-1:0] r_wr_addr;
    logic [CW-1:0] r_fill_new;
    logic          r_bv_new;
    logic          r_bpunct_new;

    logic [LW-1:0] r_eidx;
    logic          r_rd_vld;
    logic          r_rd_nl;
    logic [63:0]   r_acc;
    logic [3:0]    r_acc_cnt;
    logic [CW-1:0] r_midx;
    logic          r_mv_vld;
    logic [AW-1:0] r_mv_dst;

    logic          r_out_vld;
    logic [63:0]   r_out_bytes;
    logic [3:0]    r_out_cnt;
    logic          r_out_last;

    logic [CW-1:0] w_eff;
    logic          full;
    logic          cand;
    logic          out_free;
    logic          emit_iss;
    logic          from_mem;
    logic          emit_tail;
    logic          word_go;
    logic          move_iss;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    rd_byte;
    logic [63:0]   n_acc;
    logic [CW-1:0] keep;

    logic [LW-1:0] p_len;
    logic [LW-1:0] p_mem_len;
    logic [CW-1:0] p_tail;
    logic          p_wr_c;
    logic [AW-1:0] p_wr_addr;
    logic [CW-1:0] p_fill_new;
    logic          p_bv_new;
    logic          p_bpunct_new;

    always_comb begin
        if (r_line_width == 8'd0) begin
            w_eff = CW'(1);
        end else if (r_line_width > 8'(LINE_MAX)) begin
            w_eff = CW'(LINE_MAX);
        end else begin
            w_eff = CW'(r_line_width);
        end
    end

    assign full = (r_fill >= w_eff);
    assign cand = (i_char_in == SPACE_BYTE) || (r_bop && is_punct(i_char_in));

    assign out_free  = !r_out_vld || i_ready;
    assign from_mem  = (r_eidx < r_mem_len);
    assign emit_iss  = i_cmd.emit && (r_eidx != r_len) && ((r_acc_cnt + 4'(r_rd_vld)) < 4'd8);
    assign emit_tail = (r_eidx == r_len) && !r_rd_vld;
    assign word_go   = i_cmd.emit && out_free &&
                       ((r_acc_cnt == 4'd8) || ((r_acc_cnt != 4'd0) && emit_tail));
    assign move_iss  = i_cmd.move && (r_midx != r_tail);
    assign rd_byte   = r_rd_nl ? NEWLINE_BYTE : r_mem_q;

    assign mem_re    = (emit_iss && from_mem) || move_iss;
    assign mem_raddr = i_cmd.move ? AW'(r_src + r_midx) : r_eidx[AW-1:0];

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_wr_addr;
        mem_wdata = r_c;
        if (i_cmd.append) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(r_fill);
            mem_wdata = i_char_in;
        end else if (r_mv_vld) begin
            mem_we    = 1'b1;
            mem_waddr = r_mv_dst;
            mem_wdata = r_mem_q;
        end else if (i_cmd.finish && r_wr_c) begin
            mem_we    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_raddr];
        end
    end

    always_comb begin
        n_acc = r_acc;
        if (word_go) begin
            n_acc = '0;
        end else if (r_rd_vld) begin
            for (int k = 0; k < 8; k++) begin
                if (r_acc_cnt == 4'(k)) begin
                    n_acc[8*k +: 8] = rd_byte;
                end
            end
        end
    end

    assign keep = CW'(r_bp) + CW'(r_bpunct);

    always_comb begin
        p_len        = LW'(r_fill) + LW'(1);
        p_mem_len    = LW'(r_fill);
        p_tail       = '0;
        p_wr_c       = 1'b0;
        p_wr_addr    = '0;
        p_fill_new   = '0;
        p_bv_new     = 1'b0;
        p_bpunct_new = 1'b0;
        if (i_end_of_text) begin
            p_len = LW'(r_fill);
        end else if (r_bv) begin
            p_mem_len  = LW'(keep);
            p_len      = LW'(keep) + LW'(1);
            p_tail     = r_fill - CW'(r_bp) - CW'(1);
            p_wr_c     = 1'b1;
            p_wr_addr  = AW'(p_tail);
            p_fill_new = p_tail + CW'(1);
        end else if (i_char_in != SPACE_BYTE) begin
            p_wr_c       = 1'b1;
            p_fill_new   = CW'(1);
            p_bv_new     = r_bop && is_punct(i_char_in);
            p_bpunct_new = is_punct(i_char_in);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_c          <= i_char_in;
            r_len        <= p_len;
            r_mem_len    <= p_mem_len;
            r_tail       <= p_tail;
            r_src        <= CW'(r_bp) + CW'(1);
            r_wr_c       <= p_wr_c;
            r_wr_addr    <= p_wr_addr;
            r_fill_new   <= p_fill_new;
            r_bv_new     <= p_bv_new;
            r_bpunct_new <= p_bpunct_new;
        end
        if (i_cmd.start) begin
            r_eidx <= '0;
        end else if (emit_iss) begin
            r_eidx <= r_eidx + LW'(1);
        end
        if (i_cmd.start) begin
            r_midx <= '0;
        end else if (move_iss) begin
            r_midx <= r_midx + CW'(1);
        end
        r_rd_nl  <= !from_mem;
        r_mv_dst <= AW'(r_midx);
        if (word_go) begin
            r_out_bytes <= r_acc;
            r_out_cnt   <= r_acc_cnt;
            r_out_last  <= emit_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RST;
            r_bop        <= BREAK_PUNCT_RST;
            r_fill       <= '0;
            r_bp         <= '0;
            r_bv         <= 1'b0;
            r_bpunct     <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_mv_vld     <= 1'b0;
            r_acc        <= '0;
            r_acc_cnt    <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_LINE_WIDTH) begin
                r_line_width <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == CFG_BREAK_PUNCT) begin
                r_bop <= i_cfg_data[0];
            end
            if (i_cmd.append) begin
                r_fill <= r_fill + CW'(1);
                if (cand) begin
                    r_bp     <= AW'(r_fill);
                    r_bv     <= 1'b1;
                    r_bpunct <= is_punct(i_char_in);
                end
            end else if (i_cmd.finish) begin
                r_fill   <= r_fill_new;
                r_bp     <= '0;
                r_bv     <= r_bv_new;
                r_bpunct <= r_bpunct_new;
            end
            r_rd_vld <= emit_iss;
            r_mv_vld <= move_iss;
            r_acc    <= n_acc;
            if (word_go) begin
                r_acc_cnt <= '0;
            end else if (r_rd_vld) begin
                r_acc_cnt <= r_acc_cnt + 4'd1;
            end
            if (word_go) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_status.needs_fold = i_end_of_text || full;
    assign o_status.emit_done  = emit_tail && (r_acc_cnt == 4'd0);
    assign o_status.move_done  = (r_midx == r_tail) && !r_mv_vld;

    assign o_valid     = r_out_vld;
    assign o_out_bytes = r_out_bytes;
    assign o_out_count = r_out_cnt;
    assign o_last      = r_out_last;

endmodule

### design/word_wrap_line_folder.sv
// An ordinary byte into a line with room is appended without leaving idle and yields no result.
// A byte at a full line or an end marker starts a fold: input is held off while the controller
// steps through emit, move and finish, and any folded text leaves as packed words of up to eight bytes.
// Synchronous active-low reset empties the line, clears the break and output state and sets
// line_width to 80 and break_on_punct to 0; the line memory itself is not cleared.
`include "word_wrap_line_folder_macros.svh"

module word_wrap_line_folder
    import wwlf_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_char_in,
    input  logic                  i_end_of_text,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [63:0]           o_out_bytes,
    output logic [3:0]            o_out_count,
    output logic                  o_last,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    wwlf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    wwlf_dp #(
        .LINE_MAX (LINE_MAX)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_char_in     (i_char_in),
        .i_end_of_text (i_end_of_text),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_out_bytes   (o_out_bytes),
        .o_out_count   (o_out_count),
        .o_last        (o_last)
    );

    // A partly filled word can only close a fold.
    `WWLF_ASSERT_SAME(a_partial_is_last, i_clk, i_rst_n, o_valid && (o_out_count != 4'd8), o_last)
    `WWLF_ASSERT_SAME(a_count_nonzero, i_clk, i_rst_n, o_valid, (o_out_count != 4'd0) && (o_out_count <= 4'd8))
    `WWLF_ASSERT_NEXT(a_fold_blocks_input, i_clk, i_rst_n, cmd.start, !o_ready)
    `WWLF_ASSERT_NEXT(a_finish_reopens, i_clk, i_rst_n, cmd.finish, o_ready)

endmodule

### bench/word_wrap_line_folder_tb.sv
// Self-checking testbench of the word wrap line folder: directed table, random text, line predictor.
module word_wrap_line_folder_tb
    import wwlf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES   = 320;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 600;
    localparam int IDLE_PCT       = 27;

    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  count;
        logic        last;
    } t_word;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct packed {
        t_row_kind               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [7:0]              value;
        logic                    eot;
        logic                    typed;
        t_word                   want;
    } t_row;

    typedef struct {
        int width;
        int punct;
        int items;
        int space_pct;
        int punct_pct;
        int eot_pct;
        bit no_idle;
        bit press;
    } t_phase;

    localparam t_word NO_WORD = '0;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [7:0]            i_char_in = 8'h00;
    logic                  i_end_of_text = 1'b0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [63:0]           o_out_bytes;
    logic [3:0]            o_out_count;
    logic                  o_last;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic [7:0] line_mem [LINE_MAX_DEF];
    int         fill_cnt = 0;
    int         brk_pos = 0;
    bit         brk_ok = 1'b0;
    int         width_reg = int'(LINE_WIDTH_RST);
    bit         punct_reg = BREAK_PUNCT_RST;
    logic [7:0] line_text [$];
    t_word      fold_out [$];
    t_word      folded_words [$];

    int mismatches = 0;
    int idle_cycles = 0;
    bit steady = 1'b0;
    bit hold_req = 1'b0;

    t_row dir_table [31] = '{
        '{ROW_ITEM, '0, 8'hFF, 1'b1, 1'b0, NO_WORD},
        '{ROW_ITEM, '0, 8'h41, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, '0, 8'h00, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, '0, 8'h00, 1'b1, 1'b1, '{64'h0041, 4'd2, 1'b1}},
        '{ROW_CFG, CFG_LINE_WIDTH, 8'd1, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, '0, 8'hFF, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, '0, 8'h80, 1'b0, 1'b1, '{64'h0AFF, 4'd2, 1'b1}},
        '{ROW_ITEM, '0, SPACE_BYTE, 1'b0, 1'b1, '{64'h0A80, 4'd2, 1'b1}},
        '{ROW_CFG, CFG_LINE_WIDTH, 8'd4, 1'b0, 1'b0, NO_WORD},
        '{ROW_CFG, CFG_BREAK_PUNCT, 8'd1, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, '0, 8'h77, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, '0, 8'h78, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, '0, 8'h79, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, '0, 8'h7A, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, '0, 8'h3F, 1'b0, 1'b1, '{64'h0A7A797877, 4'd5, 1'b1}},
        '{ROW_ITEM, '0, 8'h61, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, '0, 8'h62, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, '0, 8'h63, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, '0, 8'h64, 1'b0, 1'b1, '{64'h0A3F, 4'd2, 1'b1}},
        '{ROW_ITEM, '0, 8'h65, 1'b0, 1'b1, '{64'h0A64636261, 4'd5, 1'b1}},
        '{ROW_ITEM, '0, 8'hA5, 1'b1, 1'b1, '{64'h65, 4'd1, 1'b1}},
        '{ROW_CFG, CFG_LINE_WIDTH, 8'd80, 1'b0, 1'b0, NO_WORD},
        '{ROW_CFG, CFG_BREAK_PUNCT, 8'd0, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, '0, 8'h68, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, '0, 8'h69, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, '0, SPACE_BYTE, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, '0, 8'h79, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, '0, 8'h6F, 1'b0, 1'b0, NO_WORD},
        '{ROW_CFG, CFG_LINE_WIDTH, 8'd2, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, '0, 8'h75, 1'b0, 1'b1, '{64'h0A6968, 4'd3, 1'b1}},
        '{ROW_ITEM, '0, 8'h5A, 1'b1, 1'b1, '{64'h756F79, 4'd3, 1'b1}}
    };

    t_phase plan [6] = '{
        '{0,   1, 25,  15, 15, 5, 1'b0, 1'b0},
        '{255, 0, 150, 1,  10, 0, 1'b0, 1'b0},
        '{7,   1, 40,  15, 10, 4, 1'b0, 1'b1},
        '{16,  0, 40,  18, 5,  3, 1'b1, 1'b0},
        '{128, 1, 20,  12, 8,  2, 1'b0, 1'b0},
        '{3,   0, 15,  20, 5,  5, 1'b0, 1'b0}
    };

    word_wrap_line_folder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_char_in     (i_char_in),
        .i_end_of_text (i_end_of_text),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_bytes   (o_out_bytes),
        .o_out_count   (o_out_count),
        .o_last        (o_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5ns i_clk = ~i_clk;

    function automatic bit is_mark(input logic [7:0] c);
        return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

    // Updates the line state for one byte and leaves the packed output words in fold_out.
    function automatic void fold_byte(input logic [7:0] c, input logic eot);
        int w;
        int keep;
        int tail;
        int n;
        t_word wd;
        line_text.delete();
        fold_out.delete();
        w = width_reg;
        if (w < 1) w = 1;
        if (w > LINE_MAX_DEF) w = LINE_MAX_DEF;
        if (eot) begin
            n = (fill_cnt > LINE_MAX_DEF) ? LINE_MAX_DEF : fill_cnt;
            for (int i = 0; i < n; i++) line_text.push_back(line_mem[i]);
            fill_cnt = 0;
            brk_pos = 0;
            brk_ok = 1'b0;
        end else if (fill_cnt < w) begin
            line_mem[fill_cnt] = c;
            if (c == SPACE_BYTE || (punct_reg && is_mark(c))) begin
                brk_pos = fill_cnt;
                brk_ok = 1'b1;
            end
            fill_cnt++;
        end else if (brk_ok && brk_pos < fill_cnt) begin
            keep = is_mark(line_mem[brk_pos]) ? brk_pos + 1 : brk_pos;
            for (int i = 0; i < keep; i++) line_text.push_back(line_mem[i]);
            line_text.push_back(NEWLINE_BYTE);
            tail = fill_cnt - brk_pos - 1;
            for (int i = 0; i < tail; i++) line_mem[i] = line_mem[brk_pos + 1 + i];
            line_mem[tail] = c;
            fill_cnt = tail + 1;
            brk_pos = 0;
            brk_ok = 1'b0;
        end else begin
            for (int i = 0; i < fill_cnt; i++) line_text.push_back(line_mem[i]);
            line_text.push_back(NEWLINE_BYTE);
            brk_pos = 0;
            brk_ok = 1'b0;
            if (c == SPACE_BYTE) begin
                fill_cnt = 0;
            end else begin
                line_mem[0] = c;
                fill_cnt = 1;
                if (punct_reg && is_mark(c)) brk_ok = 1'b1;
            end
        end
        n = line_text.size();
        for (int k = 0; k * 8 < n; k++) begin
            wd = NO_WORD;
            wd.count = (n - k * 8 > 8) ? 4'd8 : 4'(n - k * 8);
            for (int j = 0; j < wd.count; j++) wd.bytes[8*j +: 8] = line_text[k * 8 + j];
            wd.last = ((k + 1) * 8 >= n);
            fold_out.push_back(wd);
        end
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic eot, input logic typed,
                             input t_word want);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_char_in <= c;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (!o_ready);
        fold_byte(c, eot);
        if (typed) folded_words.push_back(want);
        else foreach (fold_out[k]) folded_words.push_back(fold_out[k]);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (folded_words.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_LINE_WIDTH) width_reg = int'(data);
        else if (idx == CFG_BREAK_PUNCT) punct_reg = data[0];
    endtask

    initial begin
        t_row r;
        int roll;
        logic [7:0] c;
        logic eot;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_table[i]) begin
            r = dir_table[i];
            if (r.kind == ROW_CFG) begin
                settle();
                write_reg(r.idx, r.value);
            end else begin
                send_byte(r.value, r.eot, r.typed, r.want);
            end
        end
        foreach (plan[p]) begin
            settle();
            write_reg(CFG_LINE_WIDTH, CFG_DATA_W'(plan[p].width));
            write_reg(CFG_BREAK_PUNCT, CFG_DATA_W'(plan[p].punct));
            steady = plan[p].no_idle;
            hold_req = plan[p].press;
            for (int n = 0; n < plan[p].items; n++) begin
                roll = $urandom_range(0, 99);
                eot = (roll < plan[p].eot_pct);
                if (eot) begin
                    c = 8'($urandom_range(0, 255));
                end else if (roll < plan[p].eot_pct + plan[p].space_pct) begin
                    c = SPACE_BYTE;
                end else if (roll < plan[p].eot_pct + plan[p].space_pct + plan[p].punct_pct) begin
                    do c = 8'($urandom_range(33, 126)); while (!is_mark(c));
                end else if ($urandom_range(0, 3) == 0) begin
                    c = 8'($urandom_range(0, 255));
                end else begin
                    c = 8'($urandom_range(97, 122));
                end
                send_byte(c, eot, 1'b0, NO_WORD);
            end
            steady = 1'b0;
        end
        settle();
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // The receiver holds off for one long stretch so that the block backs up.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                i_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin : check_result
        t_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (folded_words.size() == 0) begin
                $error("unexpected result: out_bytes %h, out_count %0d", o_out_bytes, o_out_count);
                mismatches++;
            end else begin
                want = folded_words.pop_front();
                if (o_out_bytes !== want.bytes) begin
                    $error("out_bytes: expected %h, got %h", want.bytes, o_out_bytes);
                    mismatches++;
                end
                if (o_out_count !== want.count) begin
                    $error("out_count: expected %0d, got %0d", want.count, o_out_count);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
